FILE: rtl/core/cbfs_pkg.sv
// shared types, constants and helpers for the counting bloom frequency sketch
`default_nettype none
package cbfs_pkg;

  localparam int MAX_COUNTERS = 4096;
  localparam int MAX_HASHES   = 10;
  localparam int ADDR_W       = $clog2(MAX_COUNTERS);
  localparam int SEED_W       = $clog2(MAX_HASHES);
  localparam int CNT_W        = 32;
  localparam int NCNT_W       = 13;
  localparam int NHASH_W      = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // opcodes
  localparam logic [1:0] OP_ESTIMATE = 2'd0;
  localparam logic [1:0] OP_UPDATE   = 2'd1;
  localparam logic [1:0] OP_DECAY    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNTERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASHES   = 1'd1;

  // murmur3 constants
  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_E  = 32'he6546b64;
  localparam logic [31:0] MM_M1 = 32'h85ebca6b;
  localparam logic [31:0] MM_M2 = 32'hc2b2ae35;
  localparam logic [31:0] MM_LEN = 32'd8;

  // hash sequencer steps
  localparam logic [3:0] HS_NONE = 4'd0;
  localparam logic [3:0] HS_K0A  = 4'd1;
  localparam logic [3:0] HS_K0B  = 4'd2;
  localparam logic [3:0] HS_H0   = 4'd3;
  localparam logic [3:0] HS_K1A  = 4'd4;
  localparam logic [3:0] HS_K1B  = 4'd5;
  localparam logic [3:0] HS_H1   = 4'd6;
  localparam logic [3:0] HS_F1   = 4'd7;
  localparam logic [3:0] HS_F2   = 4'd8;

  // memory read source
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_REM  = 2'd1;
  localparam logic [1:0] RD_IDX  = 2'd2;
  localparam logic [1:0] RD_ADDR = 2'd3;

  // memory write kind
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_INC  = 2'd1;
  localparam logic [1:0] WR_HALF = 2'd2;
  localparam logic [1:0] WR_ZERO = 2'd3;

  typedef struct packed {
    logic [3:0] hstep;
    logic       mod_load;
    logic       mod_step;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic       min_upd;
    logic       min_inc;
    logic       seed_inc;
    logic       seed_clr;
    logic       addr_inc;
    logic       load;
    logic       out_load;
  } cbfs_cmd_t;

  typedef struct packed {
    logic       mod_last;
    logic       seed_last;
    logic       addr_last;
    logic       upd_ok;
    logic [1:0] op;
    logic       out_free;
  } cbfs_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cbfs_dp.sv
// datapath: murmur3 hash, modulo unit, counter memory, minimum and result register
`default_nettype none
module cbfs_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cbfs_pkg::cbfs_cmd_t          cmd,
  output cbfs_pkg::cbfs_stat_t              stat,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [63:0]                  in_key,
  input  wire logic                         cfg_wr_en,
  input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cbfs_pkg::CNT_W-1:0]        out_count
);
  import cbfs_pkg::*;

  logic [NCNT_W-1:0]  counters_in_use;
  logic [NHASH_W-1:0] num_hashes;
  logic [NCNT_W-1:0]  n_eff;
  logic [NHASH_W-1:0] h_eff;

  logic [1:0]  op;
  logic [63:0] key;
  logic [SEED_W-1:0] seed;
  logic [31:0] k;
  logic [31:0] h;
  logic [31:0] t_fin1;
  logic [31:0] t_fin2;
  logic [31:0] t_fin3;

  logic [31:0] div;
  logic [NCNT_W-1:0] rem;
  logic [NCNT_W-1:0] rem_next;
  logic [2:0]  mcnt;

  logic [ADDR_W-1:0] idx_file [MAX_HASHES];
  logic [ADDR_W-1:0] idx_sel;
  logic [ADDR_W-1:0] addr;

  logic [CNT_W-1:0] mem [MAX_COUNTERS];
  logic [CNT_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic [CNT_W-1:0] min;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      counters_in_use <= NCNT_W'(MAX_COUNTERS);
      num_hashes      <= NHASH_W'(4);
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_COUNTERS) counters_in_use <= cfg_data;
      if (cfg_index == REG_HASHES)   num_hashes <= cfg_data[NHASH_W-1:0];
    end
  end

  always_comb begin
    priority if (counters_in_use == '0) n_eff = NCNT_W'(1);
    else if (counters_in_use > NCNT_W'(MAX_COUNTERS)) n_eff = NCNT_W'(MAX_COUNTERS);
    else n_eff = counters_in_use;
    priority if (num_hashes == '0) h_eff = NHASH_W'(1);
    else if (num_hashes > NHASH_W'(MAX_HASHES)) h_eff = NHASH_W'(MAX_HASHES);
    else h_eff = num_hashes;
  end

  // hash finalizer taps
  assign t_fin1 = (h ^ MM_LEN) ^ ((h ^ MM_LEN) >> 16);
  assign t_fin2 = h ^ (h >> 13);
  assign t_fin3 = h ^ (h >> 16);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_opcode;
      key <= in_key;
    end
    if (cmd.load || cmd.seed_clr) seed <= '0;
    else if (cmd.seed_inc) seed <= seed + SEED_W'(1);
    unique case (cmd.hstep)
      HS_K0A: begin
        k <= key[31:0] * MM_C1;
        h <= 32'(seed);
      end
      HS_K0B: k <= rotl32(k, 15) * MM_C2;
      HS_H0:  h <= rotl32(h ^ k, 13) * 32'd5 + MM_E;
      HS_K1A: k <= key[63:32] * MM_C1;
      HS_K1B: k <= rotl32(k, 15) * MM_C2;
      HS_H1:  h <= rotl32(h ^ k, 13) * 32'd5 + MM_E;
      HS_F1:  h <= t_fin1 * MM_M1;
      HS_F2:  h <= t_fin2 * MM_M2;
      default: ;
    endcase
  end

  // modulo: four restoring steps per cycle
  always_comb begin
    logic [NCNT_W:0] t;
    rem_next = rem;
    for (int j = 0; j < 4; j++) begin
      t = {rem_next, div[31-j]};
      if (t >= {1'b0, n_eff}) t = t - {1'b0, n_eff};
      rem_next = t[NCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      div  <= t_fin3;
      rem  <= '0;
      mcnt <= '0;
    end else if (cmd.mod_step) begin
      div  <= div << 4;
      rem  <= rem_next;
      mcnt <= mcnt + 3'd1;
    end
  end

  assign idx_sel = idx_file[seed];

  always_ff @(posedge clk) begin
    if (cmd.rd_sel == RD_REM) idx_file[seed] <= rem[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) addr <= '0;
    else if (cmd.load) addr <= '0;
    else if (cmd.addr_inc) addr <= addr + ADDR_W'(1);
  end

  // counter memory
  always_comb begin
    unique case (cmd.rd_sel)
      RD_REM:  rd_addr = rem[ADDR_W-1:0];
      RD_IDX:  rd_addr = idx_sel;
      RD_ADDR: rd_addr = addr;
      default: rd_addr = addr;
    endcase
    wr_addr = (cmd.wr_sel == WR_INC) ? idx_sel : addr;
    unique case (cmd.wr_sel)
      WR_INC:  wr_data = (rdata == COUNT_MAX) ? rdata : rdata + CNT_W'(1);
      WR_HALF: wr_data = rdata >> 1;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) mem[wr_addr] <= wr_data;
    if (cmd.rd_sel != RD_NONE) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) min <= COUNT_MAX;
    else if (cmd.min_upd && rdata < min) min <= rdata;
    else if (cmd.min_inc) min <= min + CNT_W'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_count <= (op == OP_ESTIMATE || op == OP_UPDATE) ? min : '0;
  end

  assign stat.mod_last  = (mcnt == 3'd7);
  assign stat.seed_last = (NHASH_W'(seed) == h_eff - NHASH_W'(1));
  assign stat.addr_last = &addr;
  assign stat.upd_ok    = (op == OP_UPDATE) && (min != COUNT_MAX);
  assign stat.op        = op;
  assign stat.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: rtl/core/cbfs_ctrl.sv
// controller state machine that sequences hashing, table access and result hand-off
`default_nettype none
module cbfs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cbfs_pkg::cbfs_stat_t stat,
  output cbfs_pkg::cbfs_cmd_t       cmd
);
  import cbfs_pkg::*;

  localparam logic [4:0] ST_INIT = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_K0A  = 5'd2;
  localparam logic [4:0] ST_K0B  = 5'd3;
  localparam logic [4:0] ST_H0   = 5'd4;
  localparam logic [4:0] ST_K1A  = 5'd5;
  localparam logic [4:0] ST_K1B  = 5'd6;
  localparam logic [4:0] ST_H1   = 5'd7;
  localparam logic [4:0] ST_F1   = 5'd8;
  localparam logic [4:0] ST_F2   = 5'd9;
  localparam logic [4:0] ST_MODL = 5'd10;
  localparam logic [4:0] ST_MODS = 5'd11;
  localparam logic [4:0] ST_RD   = 5'd12;
  localparam logic [4:0] ST_MIN  = 5'd13;
  localparam logic [4:0] ST_CHK  = 5'd14;
  localparam logic [4:0] ST_URD  = 5'd15;
  localparam logic [4:0] ST_UWR  = 5'd16;
  localparam logic [4:0] ST_DRD  = 5'd17;
  localparam logic [4:0] ST_DWR  = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.wr_sel   = WR_ZERO;
        cmd.addr_inc = 1'b1;
        if (stat.addr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_K0A;
        end
      end
      ST_K0A: begin
        priority if (stat.op == OP_DECAY) begin
          state_next = ST_DRD;
        end else if (stat.op == OP_ESTIMATE || stat.op == OP_UPDATE) begin
          cmd.hstep = HS_K0A;
          state_next = ST_K0B;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_K0B: begin cmd.hstep = HS_K0B; state_next = ST_H0;  end
      ST_H0:  begin cmd.hstep = HS_H0;  state_next = ST_K1A; end
      ST_K1A: begin cmd.hstep = HS_K1A; state_next = ST_K1B; end
      ST_K1B: begin cmd.hstep = HS_K1B; state_next = ST_H1;  end
      ST_H1:  begin cmd.hstep = HS_H1;  state_next = ST_F1;  end
      ST_F1:  begin cmd.hstep = HS_F1;  state_next = ST_F2;  end
      ST_F2:  begin cmd.hstep = HS_F2;  state_next = ST_MODL; end
      ST_MODL: begin cmd.mod_load = 1'b1; state_next = ST_MODS; end
      ST_MODS: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_next = ST_RD;
      end
      ST_RD: begin cmd.rd_sel = RD_REM; state_next = ST_MIN; end
      ST_MIN: begin
        cmd.min_upd = 1'b1;
        if (stat.seed_last) begin
          state_next = ST_CHK;
        end else begin
          cmd.seed_inc = 1'b1;
          state_next = ST_K0A;
        end
      end
      ST_CHK: begin
        if (stat.upd_ok) begin
          cmd.seed_clr = 1'b1;
          state_next = ST_URD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_URD: begin cmd.rd_sel = RD_IDX; state_next = ST_UWR; end
      ST_UWR: begin
        cmd.wr_sel = WR_INC;
        if (stat.seed_last) begin
          cmd.min_inc = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.seed_inc = 1'b1;
          state_next = ST_URD;
        end
      end
      ST_DRD: begin cmd.rd_sel = RD_ADDR; state_next = ST_DWR; end
      ST_DWR: begin
        cmd.wr_sel   = WR_HALF;
        cmd.addr_inc = 1'b1;
        state_next = stat.addr_last ? ST_DONE : ST_DRD;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/counting_bloom_frequency_sketch.sv
// top level of the counting bloom frequency sketch
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata: opcode[1:0], key[65:2], zero pad to 72
//  m_*       out  m_tvalid/m_tready    m_tdata: count[31:0]
//  cfg_*     in   cfg_wr_en            cfg_index selects register, cfg_data value
//
// estimate: after the accept, per hash the murmur mix of both key words and finalizer,
// the modulo (load, then 8 steps of 4 bits) and a table read with minimum update, then
// a check and the result; update adds a read-modify-write of each selected counter
// decay walks the whole 4096-entry table, reading and halving each counter
// after reset a clearing pass zeroes the whole table; s_tready stays low
// one item at a time; the result register lets the next beat in while a result stalls
`default_nettype none
module counting_bloom_frequency_sketch (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [71:0]                       s_tdata,  // opcode, key, pad
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [31:0]                            m_tdata,  // count
  input  wire logic                              cfg_wr_en,
  input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cbfs_pkg::*;

  cbfs_cmd_t  cmd;
  cbfs_stat_t stat;

  // sequencer
  cbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hash, modulo, table and result register
  cbfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_opcode (s_tdata[1:0]),
    .in_key    (s_tdata[65:2]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_count (m_tdata)
  );

endmodule
`default_nettype wire

FILE: rtl/core/cbfs_checker.sv
// port-level checker for the counting bloom frequency sketch and its bind
`default_nettype none
module cbfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("ports not quiet after reset");

  // one item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind counting_bloom_frequency_sketch cbfs_checker u_cbfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: dv/cbfs_checker.sv
// checker: predicts sketch counts from accepted beats and compares results
`default_nettype none
module cbfs_scoreboard (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [71:0]                     s_tdata,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [31:0]                     m_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbfs_pkg::*;

  logic [CNT_W-1:0]   sketch [MAX_COUNTERS];
  logic [NCNT_W-1:0]  width_reg;
  logic [NHASH_W-1:0] depth_reg;
  logic [CNT_W-1:0]   count_q [$];

  function automatic logic [31:0] spin32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * MM_C1;
    k = spin32(k, 15);
    k = k * MM_C2;
    h = spin32(h ^ k, 13);
    return h * 32'd5 + MM_E;
  endfunction

  function automatic logic [31:0] key_hash(input logic [63:0] key, input logic [31:0] seed);
    logic [31:0] h;
    h = mix_word(seed, key[31:0]);
    h = mix_word(h, key[63:32]);
    h = h ^ MM_LEN;
    h = h ^ (h >> 16);
    h = h * MM_M1;
    h = h ^ (h >> 13);
    h = h * MM_M2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // applies one operation to the shadow table and returns the expected count
  function automatic logic [CNT_W-1:0] sketch_apply(input logic [1:0] op,
                                                    input logic [63:0] key);
    logic [31:0] n;
    int unsigned nh;
    logic [31:0] slot [MAX_HASHES];
    logic [CNT_W-1:0] least;
    if (op == OP_DECAY) begin
      for (int i = 0; i < MAX_COUNTERS; i++) sketch[i] = sketch[i] >> 1;
      return '0;
    end
    if (op != OP_ESTIMATE && op != OP_UPDATE) return '0;
    n = (width_reg == 0) ? 1 : (width_reg > MAX_COUNTERS) ? MAX_COUNTERS : width_reg;
    nh = (depth_reg == 0) ? 1 : (depth_reg > MAX_HASHES) ? MAX_HASHES : depth_reg;
    least = COUNT_MAX;
    for (int i = 0; i < nh; i++) begin
      slot[i] = key_hash(key, i) % n;
      if (sketch[slot[i]] < least) least = sketch[slot[i]];
    end
    if (op == OP_UPDATE && least < COUNT_MAX) begin
      // repeated slots get one increment per selection
      for (int i = 0; i < nh; i++)
        if (sketch[slot[i]] < COUNT_MAX) sketch[slot[i]] = sketch[slot[i]] + 1;
      least = least + 1;
    end
    return least;
  endfunction

  assign pending = count_q.size();

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COUNTERS; i++) sketch[i] = '0;
      width_reg = NCNT_W'(MAX_COUNTERS);
      depth_reg = NHASH_W'(4);
      count_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_COUNTERS) width_reg = cfg_data[NCNT_W-1:0];
        else if (cfg_index == REG_HASHES) depth_reg = cfg_data[NHASH_W-1:0];
      end
      if (s_tvalid && s_tready)
        count_q = {count_q, sketch_apply(s_tdata[1:0], s_tdata[65:2])};
      if (m_tvalid && m_tready) begin
        if (count_q.size() == 0) begin
          $error("unexpected result beat, count %0h", m_tdata);
          fail_count++;
        end else begin
          logic [CNT_W-1:0] want;
          want = count_q.pop_front();
          if (m_tdata !== want) begin
            $error("count mismatch: expected %0h actual %0h", want, m_tdata);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: dv/tb_counting_bloom_frequency_sketch.sv
// testbench top: stimulus, idling phases and verdict for the frequency sketch
`default_nettype none
module tb_counting_bloom_frequency_sketch;
  timeunit 1ns;
  timeprecision 1ps;
  import cbfs_pkg::*;

  localparam int QUIET_LIMIT = 60000;  // decay walk plus long stalls, several times over
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused opcode

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [71:0]           s_tdata;   // opcode[1:0], key[65:2], zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // count[31:0]
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int sender_idle_pct;   // chance of an idle cycle before a beat
  int rx_stall_pct;      // chance of m_tready low in a cycle
  int hold_cycles;       // long receiver hold-off, counted down by the receiver
  int quiet;
  logic [63:0] key_pool [16];

  counting_bloom_frequency_sketch u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbfs_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: cycles with no beat accepted on either channel
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[counting_bloom_frequency_sketch] ERROR");
        $finish;
      end
    end
  end

  // one input beat; valid stays high when the next beat follows with no gap
  task automatic send_beat(input logic [1:0] op, input logic [63:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, key, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // lower valid and wait until every expected count has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key;
    return {$urandom, $urandom};
  endfunction

  // mostly estimate/update on a small pool so counters climb, rare decay
  task automatic random_beats(input int count);
    int r;
    logic [1:0] op;
    logic [63:0] key;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 2) op = OP_DECAY;
      else if (r < 4) op = OP_SPARE;
      else if (r < 60) op = OP_UPDATE;
      else op = OP_ESTIMATE;
      key = ($urandom_range(3) == 0) ? rand_key() : key_pool[$urandom_range(15)];
      send_beat(op, key);
    end
  endtask

  initial begin
    int widths [8] = '{4096, 1, 4096, 0, 8191, 7, 100, 13};
    int depths [8] = '{4, 1, 10, 0, 15, 3, 11, 1};
    int idle_s [4] = '{0, 75, 0, 19};
    int idle_r [4] = '{0, 0, 75, 19};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings: key extremes, every opcode
    send_beat(OP_ESTIMATE, 64'd0);
    send_beat(OP_UPDATE, 64'd0);
    send_beat(OP_UPDATE, 64'd0);
    send_beat(OP_UPDATE, '1);
    send_beat(OP_ESTIMATE, '1);
    send_beat(OP_ESTIMATE, 64'h8000_0000_0000_0001);
    send_beat(OP_SPARE, '1);
    send_beat(OP_DECAY, 64'h1234);
    send_beat(OP_ESTIMATE, 64'd0);
    drain();
    // single counter: every hash hits the same slot, repeated index
    write_reg(REG_COUNTERS, 1);
    write_reg(REG_HASHES, 10);
    send_beat(OP_UPDATE, 64'h5555_5555_5555_5555);
    send_beat(OP_UPDATE, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(OP_ESTIMATE, 64'd7);
    send_beat(OP_DECAY, 64'd0);
    send_beat(OP_ESTIMATE, 64'd7);
    drain();
    // zero and oversized settings act as one and the maximum
    write_reg(REG_COUNTERS, 0);
    write_reg(REG_HASHES, 0);
    send_beat(OP_UPDATE, 64'd3);
    send_beat(OP_ESTIMATE, 64'd3);
    drain();
    write_reg(REG_COUNTERS, 8191);
    write_reg(REG_HASHES, 15);
    send_beat(OP_UPDATE, 64'd3);
    send_beat(OP_ESTIMATE, 64'd3);
    drain();

    // random part: eight settings, each across the idling phases
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_COUNTERS, widths[p]);
      write_reg(REG_HASHES, depths[p]);
      for (int q = 0; q < 4; q++) begin
        sender_idle_pct = idle_s[q];
        rx_stall_pct = idle_r[q];
        if (p == 2 && q == 0) hold_cycles = 400;  // back up the block while beats keep coming
        random_beats(25);
      end
      drain();
    end

    sender_idle_pct = 0;
    rx_stall_pct = 0;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[counting_bloom_frequency_sketch] OK");
    end else begin
      $display("[counting_bloom_frequency_sketch] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/cbfs_pkg.sv
rtl/core/cbfs_dp.sv
rtl/core/cbfs_ctrl.sv
rtl/core/counting_bloom_frequency_sketch.sv
rtl/core/cbfs_checker.sv
dv/cbfs_checker.sv
dv/tb_counting_bloom_frequency_sketch.sv
